// ===== src/rvr_pkg.sv =====
// Shared constants, tables and types for the Rodrigues vector rotator.
// Depends on nothing; every other file but rvr_delay refers to it by scoped names.
`timescale 1ns / 1ps

package rvr_pkg;

    localparam int QF           = 30;          // fraction bits of unit-scale values
    localparam int SH_W         = 5;           // axis prescale shift count
    localparam int SC_W         = 32;          // prescaled axis magnitude
    localparam int SQ_W         = 64;          // squares, sum, sqrt remainder
    localparam int SQRT_STEPS   = 32;
    localparam int N_W          = 32;          // axis norm
    localparam int NUM_W        = 62;          // divider numerator
    localparam int DIV_STEPS    = 31;
    localparam int Q_W          = 31;          // divider quotient
    localparam int K_W          = 32;          // unit axis component, Q.30
    localparam int CS_W         = 33;          // cosine / sine, Q.30
    localparam int ZW           = 35;          // angle, Q.30
    localparam int CORDIC_STEPS = 30;

    localparam int AXIS_LAT = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int COMB_LAT = 6;

    localparam int RND_HALF = 536870912;       // 2^29
    localparam int Q30_ONE  = 1073741824;      // 2^30

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128,
        35'sd64,        35'sd32,        35'sd16,        35'sd8,
        35'sd4,         35'sd2
    };

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } axis_flags_t;

    // subtract steps of the angle range reduction
    function automatic int red_steps(input int w, input int f);
        return (w - f > 1) ? (w - f - 1) : 1;
    endfunction

    function automatic int sincos_lat(input int w, input int f);
        return red_steps(w, f) + CORDIC_STEPS + 5;
    endfunction

endpackage

// ===== src/rodrigues_vector_rotate_top.sv =====
// Top level of the Rodrigues vector rotator: input/output handshake, valid
// pipeline and alignment delays. Depends on rvr_pkg and all rvr_* modules.
`timescale 1ns / 1ps

// Rotates vec about axis by turn_angle (radians), all signed fixed point
// with FRAC_BITS fraction bits, using v*cos + (k x v)*sin + k*(k.v)*(1-cos)
// with k the axis scaled to unit length. A zero axis gives v*cos.
// Components saturate to the signed DATA_WIDTH range.
//
// Channels: one input item (vec_*, axis_*, turn_angle) moves on
// item_valid/item_ready, one result item (rot_*) on rot_valid/rot_ready.
// Every input item produces exactly one result item, in order.
//
// Throughput: one item per cycle unless a waiting result stalls the output.
// The depth from acceptance to rot_valid is set by the axis path (4 prescale/
// square stages, 32 square root stages, 32 divider stages, 1 sign stage) plus
// 6 combine stages; the sine/cosine CORDIC runs in parallel, delayed to match.
//
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken. When the receiver holds rot_ready low
// with a result waiting, every stage holds and item_ready drops; nothing is
// lost or repeated. Reset clears the valid pipeline only; no clearing pass.

module rodrigues_vector_rotate_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic signed [DATA_WIDTH-1:0] vec_z,
    input  logic signed [DATA_WIDTH-1:0] axis_x,
    input  logic signed [DATA_WIDTH-1:0] axis_y,
    input  logic signed [DATA_WIDTH-1:0] axis_z,
    input  logic signed [DATA_WIDTH-1:0] turn_angle,
    output logic                         rot_valid,
    input  logic                         rot_ready,
    output logic signed [DATA_WIDTH-1:0] rot_x,
    output logic signed [DATA_WIDTH-1:0] rot_y,
    output logic signed [DATA_WIDTH-1:0] rot_z
);

    localparam int W      = DATA_WIDTH;
    localparam int CS_W   = rvr_pkg::CS_W;
    localparam int K_W    = rvr_pkg::K_W;
    localparam int SC_LAT = rvr_pkg::sincos_lat(DATA_WIDTH, FRAC_BITS);
    localparam int CS_DLY = rvr_pkg::AXIS_LAT - SC_LAT;
    localparam int TOTAL  = rvr_pkg::AXIS_LAT + rvr_pkg::COMB_LAT;

    logic                    en;
    logic [TOTAL-1:0]        valid_reg;

    logic signed [K_W-1:0]   k_x;
    logic signed [K_W-1:0]   k_y;
    logic signed [K_W-1:0]   k_z;
    logic signed [CS_W-1:0]  cos_raw;
    logic signed [CS_W-1:0]  sin_raw;
    logic [2*CS_W-1:0]       cs_dly;
    logic [3*W-1:0]          vec_dly;

    // global stage enable: move unless a finished result is stuck
    assign en         = !valid_reg[TOTAL-1] || rot_ready;
    assign item_ready = en;
    assign rot_valid  = valid_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[TOTAL-2:0], item_valid};
        end
    end

    rvr_axis_norm #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_axis (
        .clk    (clk),
        .en     (en),
        .axis_x (axis_x),
        .axis_y (axis_y),
        .axis_z (axis_z),
        .k_x    (k_x),
        .k_y    (k_y),
        .k_z    (k_z)
    );

    rvr_sincos #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_sincos (
        .clk        (clk),
        .en         (en),
        .turn_angle (turn_angle),
        .cos_v      (cos_raw),
        .sin_v      (sin_raw)
    );

    // cos/sin finish early; hold them until the unit axis is ready
    rvr_delay #(
        .WIDTH (2 * CS_W),
        .DEPTH (CS_DLY)
    ) u_cs_dly (
        .clk  (clk),
        .en   (en),
        .din  ({cos_raw, sin_raw}),
        .dout (cs_dly)
    );

    rvr_delay #(
        .WIDTH (3 * W),
        .DEPTH (rvr_pkg::AXIS_LAT)
    ) u_vec_dly (
        .clk  (clk),
        .en   (en),
        .din  ({vec_x, vec_y, vec_z}),
        .dout (vec_dly)
    );

    rvr_combine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_combine (
        .clk   (clk),
        .en    (en),
        .vec_x ($signed(vec_dly[3*W-1:2*W])),
        .vec_y ($signed(vec_dly[2*W-1:W])),
        .vec_z ($signed(vec_dly[W-1:0])),
        .k_x   (k_x),
        .k_y   (k_y),
        .k_z   (k_z),
        .cos_v ($signed(cs_dly[2*CS_W-1:CS_W])),
        .sin_v ($signed(cs_dly[CS_W-1:0])),
        .rot_x (rot_x),
        .rot_y (rot_y),
        .rot_z (rot_z)
    );

endmodule

// ===== src/rvr_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipeline.
// Depends on nothing.
`timescale 1ns / 1ps

module rvr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== src/rvr_axis_norm.sv =====
// Axis normalization: prescale, sum of squares, pipelined square root and
// three pipelined restoring dividers. Depends on rvr_pkg.
`timescale 1ns / 1ps

module rvr_axis_norm #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [DATA_WIDTH-1:0]      axis_x,
    input  logic signed [DATA_WIDTH-1:0]      axis_y,
    input  logic signed [DATA_WIDTH-1:0]      axis_z,
    output logic signed [rvr_pkg::K_W-1:0]    k_x,
    output logic signed [rvr_pkg::K_W-1:0]    k_y,
    output logic signed [rvr_pkg::K_W-1:0]    k_z
);

    localparam int W     = DATA_WIDTH;
    localparam int SH_W  = rvr_pkg::SH_W;
    localparam int SC_W  = rvr_pkg::SC_W;
    localparam int SQ_W  = rvr_pkg::SQ_W;
    localparam int SQS   = rvr_pkg::SQRT_STEPS;
    localparam int N_W   = rvr_pkg::N_W;
    localparam int NUM_W = rvr_pkg::NUM_W;
    localparam int DVS   = rvr_pkg::DIV_STEPS;
    localparam int Q_W   = rvr_pkg::Q_W;
    localparam int K_W   = rvr_pkg::K_W;
    localparam int DV_W  = NUM_W + 1;

    logic [W-1:0]                 raw [3];
    logic [W-1:0]                 mag_next [3];
    logic [W-1:0]                 mag_reg [3];
    logic [W-1:0]                 any_bits;
    logic [SH_W-1:0]              sh_next;
    logic [SH_W-1:0]              sh_reg;
    rvr_pkg::axis_flags_t         fl_next;
    rvr_pkg::axis_flags_t         fl1_reg;
    rvr_pkg::axis_flags_t         fl2_reg;
    rvr_pkg::axis_flags_t         fl3_reg;
    logic [SC_W-1:0]              sc2_reg [3];
    logic [SC_W-1:0]              sc3_reg [3];
    logic [SQ_W-1:0]              sq3_reg [3];
    logic [SQ_W-1:0]              sum_next;

    // square root pipeline
    logic [SQ_W-1:0]              rem_reg [SQS+1];
    logic [SQ_W-1:0]              res_reg [SQS+1];
    logic [SC_W-1:0]              scp_reg [SQS+1][3];
    rvr_pkg::axis_flags_t         flp_reg [SQS+1];
    logic [SQ_W-1:0]              bitv [SQS];
    logic [SQ_W:0]                trial [SQS];
    logic [SQ_W-1:0]              rem_next [SQS];
    logic [SQ_W-1:0]              res_next [SQS];

    // divider pipeline
    logic [N_W-1:0]               nrm;
    logic [NUM_W-1:0]             num_reg [DVS+1][3];
    logic [Q_W-1:0]               q_reg [DVS+1][3];
    logic [N_W-1:0]               dn_reg [DVS+1];
    rvr_pkg::axis_flags_t         fld_reg [DVS+1];
    logic [DV_W-1:0]              dvs [DVS];
    logic [NUM_W-1:0]             num_next [DVS][3];
    logic [Q_W-1:0]               q_next [DVS][3];
    logic [NUM_W-1:0]             num0_next [3];

    logic signed [K_W-1:0]        kq [3];
    logic signed [K_W-1:0]        k_next [3];
    logic signed [K_W-1:0]        k_reg [3];

    assign raw[0] = axis_x;
    assign raw[1] = axis_y;
    assign raw[2] = axis_z;

    // magnitudes and the shift that brings the largest to [2^30, 2^31)
    always_comb
    begin
        any_bits = '0;
        sh_next  = '0;
        for (int i = 0; i < 3; i++)
        begin
            fl_next.neg[i] = raw[i][W-1];
            mag_next[i]    = raw[i][W-1] ? (~raw[i] + 1'b1) : raw[i];
            any_bits       = any_bits | mag_next[i];
        end
        fl_next.zero = (any_bits == '0);
        for (int b = 0; b < W; b++)
        begin
            if (any_bits[b])
            begin
                sh_next = (b < rvr_pkg::QF) ? SH_W'(rvr_pkg::QF - b) : '0;
            end
        end
    end

    always_comb
    begin
        sum_next = sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
    end

    always_comb
    begin
        for (int t = 0; t < SQS; t++)
        begin
            bitv[t]  = SQ_W'(1) << (SQ_W - 2 - 2 * t);
            trial[t] = {1'b0, res_reg[t]} + {1'b0, bitv[t]};
            if ({1'b0, rem_reg[t]} >= trial[t])
            begin
                rem_next[t] = rem_reg[t] - trial[t][SQ_W-1:0];
                res_next[t] = (res_reg[t] >> 1) + bitv[t];
            end
            else
            begin
                rem_next[t] = rem_reg[t];
                res_next[t] = res_reg[t] >> 1;
            end
        end
    end

    // numerator |sc| * 2^30 + n/2
    assign nrm = res_reg[SQS][N_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num0_next[i] = (NUM_W'(scp_reg[SQS][i]) << rvr_pkg::QF) + NUM_W'(nrm >> 1);
        end
    end

    always_comb
    begin
        for (int t = 0; t < DVS; t++)
        begin
            dvs[t] = DV_W'(dn_reg[t]) << (DVS - 1 - t);
            for (int i = 0; i < 3; i++)
            begin
                if (DV_W'(num_reg[t][i]) >= dvs[t])
                begin
                    num_next[t][i] = num_reg[t][i] - NUM_W'(dvs[t]);
                    q_next[t][i]   = q_reg[t][i] | (Q_W'(1) << (DVS - 1 - t));
                end
                else
                begin
                    num_next[t][i] = num_reg[t][i];
                    q_next[t][i]   = q_reg[t][i];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kq[i] = K_W'(q_reg[DVS][i]);
            if (fld_reg[DVS].zero)
            begin
                k_next[i] = '0;
            end
            else if (fld_reg[DVS].neg[i])
            begin
                k_next[i] = -kq[i];
            end
            else
            begin
                k_next[i] = kq[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_next[i];
                sc2_reg[i] <= SC_W'(mag_reg[i]) << sh_reg;
                sc3_reg[i] <= sc2_reg[i];
                sq3_reg[i] <= SQ_W'(sc2_reg[i]) * SQ_W'(sc2_reg[i]);
                scp_reg[0][i] <= sc3_reg[i];
                num_reg[0][i] <= num0_next[i];
                q_reg[0][i]   <= '0;
                k_reg[i]      <= k_next[i];
            end
            sh_reg  <= sh_next;
            fl1_reg <= fl_next;
            fl2_reg <= fl1_reg;
            fl3_reg <= fl2_reg;

            rem_reg[0] <= sum_next;
            res_reg[0] <= '0;
            flp_reg[0] <= fl3_reg;
            for (int t = 0; t < SQS; t++)
            begin
                rem_reg[t+1] <= rem_next[t];
                res_reg[t+1] <= res_next[t];
                flp_reg[t+1] <= flp_reg[t];
                for (int i = 0; i < 3; i++)
                begin
                    scp_reg[t+1][i] <= scp_reg[t][i];
                end
            end

            dn_reg[0]  <= nrm;
            fld_reg[0] <= flp_reg[SQS];
            for (int t = 0; t < DVS; t++)
            begin
                dn_reg[t+1]  <= dn_reg[t];
                fld_reg[t+1] <= fld_reg[t];
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[t+1][i] <= num_next[t][i];
                    q_reg[t+1][i]   <= q_next[t][i];
                end
            end
        end
    end

    assign k_x = k_reg[0];
    assign k_y = k_reg[1];
    assign k_z = k_reg[2];

endmodule

// ===== src/rvr_sincos.sv =====
// Angle range reduction and a 30-stage pipelined CORDIC for cos and sin.
// Depends on rvr_pkg.
`timescale 1ns / 1ps

module rvr_sincos #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [DATA_WIDTH-1:0]      turn_angle,
    output logic signed [rvr_pkg::CS_W-1:0]   cos_v,
    output logic signed [rvr_pkg::CS_W-1:0]   sin_v
);

    localparam int W    = DATA_WIDTH;
    localparam int RED  = rvr_pkg::red_steps(DATA_WIDTH, FRAC_BITS);
    localparam int RW   = DATA_WIDTH + 31 - FRAC_BITS;
    localparam int ZW   = rvr_pkg::ZW;
    localparam int CS_W = rvr_pkg::CS_W;
    localparam int CS   = rvr_pkg::CORDIC_STEPS;

    logic signed [RW-1:0]  a_ext;
    logic [RW-1:0]         amag;
    logic [RW-1:0]         rm_reg [RED+1];
    logic                  neg_reg [RED+1];
    logic [63:0]           thr [RED];
    logic [RW-1:0]         rm_next [RED];
    logic signed [ZW-1:0]  rpos;
    logic signed [ZW-1:0]  rs_reg;
    logic signed [ZW-1:0]  rw_next;
    logic signed [ZW-1:0]  rw_reg;
    logic signed [ZW-1:0]  rf_next;
    logic                  flip_next;

    logic signed [ZW-1:0]   z_reg [CS+1];
    logic signed [CS_W-1:0] x_reg [CS+1];
    logic signed [CS_W-1:0] y_reg [CS+1];
    logic                   flip_reg [CS+1];
    logic signed [ZW-1:0]   z_next [CS];
    logic signed [CS_W-1:0] x_next [CS];
    logic signed [CS_W-1:0] y_next [CS];
    logic signed [CS_W-1:0] cos_reg;
    logic signed [CS_W-1:0] sin_reg;

    always_comb
    begin
        a_ext = RW'(turn_angle) <<< (rvr_pkg::QF - FRAC_BITS);
        amag  = turn_angle[W-1] ? RW'(-a_ext) : RW'(a_ext);
    end

    // magnitude mod 2*pi, one conditional subtract per stage
    always_comb
    begin
        for (int t = 0; t < RED; t++)
        begin
            thr[t] = 64'(rvr_pkg::TWO_PI_Q30) << (RED - 1 - t);
            if (64'(rm_reg[t]) >= thr[t])
            begin
                rm_next[t] = rm_reg[t] - RW'(thr[t]);
            end
            else
            begin
                rm_next[t] = rm_reg[t];
            end
        end
    end

    assign rpos = ZW'(rm_reg[RED]);

    always_comb
    begin
        rw_next = rs_reg;
        if (rs_reg > rvr_pkg::PI_Q30)
        begin
            rw_next = rs_reg - rvr_pkg::TWO_PI_Q30;
        end
        else if (rs_reg < -rvr_pkg::PI_Q30)
        begin
            rw_next = rs_reg + rvr_pkg::TWO_PI_Q30;
        end
    end

    // fold into [-pi/2, pi/2]; results of a fold get negated
    always_comb
    begin
        rf_next   = rw_reg;
        flip_next = 1'b0;
        if (rw_reg > rvr_pkg::HALF_PI_Q30)
        begin
            rf_next   = rw_reg - rvr_pkg::PI_Q30;
            flip_next = 1'b1;
        end
        else if (rw_reg < -rvr_pkg::HALF_PI_Q30)
        begin
            rf_next   = rw_reg + rvr_pkg::PI_Q30;
            flip_next = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CS; i++)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - rvr_pkg::ATAN_Q30[i];
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + rvr_pkg::ATAN_Q30[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rm_reg[0]  <= amag;
            neg_reg[0] <= turn_angle[W-1];
            for (int t = 0; t < RED; t++)
            begin
                rm_reg[t+1]  <= rm_next[t];
                neg_reg[t+1] <= neg_reg[t];
            end
            rs_reg <= neg_reg[RED] ? -rpos : rpos;
            rw_reg <= rw_next;

            z_reg[0]    <= rf_next;
            x_reg[0]    <= rvr_pkg::CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            flip_reg[0] <= flip_next;
            for (int i = 0; i < CS; i++)
            begin
                z_reg[i+1]    <= z_next[i];
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                flip_reg[i+1] <= flip_reg[i];
            end

            cos_reg <= flip_reg[CS] ? -x_reg[CS] : x_reg[CS];
            sin_reg <= flip_reg[CS] ? -y_reg[CS] : y_reg[CS];
        end
    end

    assign cos_v = cos_reg;
    assign sin_v = sin_reg;

endmodule

// ===== src/rvr_combine.sv =====
// Rodrigues combination: dot and cross products, scaling by cos, sin and
// 1-cos, rounding and saturation, six register stages. Depends on rvr_pkg.
`timescale 1ns / 1ps

module rvr_combine #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [DATA_WIDTH-1:0]      vec_x,
    input  logic signed [DATA_WIDTH-1:0]      vec_y,
    input  logic signed [DATA_WIDTH-1:0]      vec_z,
    input  logic signed [rvr_pkg::K_W-1:0]    k_x,
    input  logic signed [rvr_pkg::K_W-1:0]    k_y,
    input  logic signed [rvr_pkg::K_W-1:0]    k_z,
    input  logic signed [rvr_pkg::CS_W-1:0]   cos_v,
    input  logic signed [rvr_pkg::CS_W-1:0]   sin_v,
    output logic signed [DATA_WIDTH-1:0]      rot_x,
    output logic signed [DATA_WIDTH-1:0]      rot_y,
    output logic signed [DATA_WIDTH-1:0]      rot_z
);

    localparam int W    = DATA_WIDTH;
    localparam int K_W  = rvr_pkg::K_W;
    localparam int CS_W = rvr_pkg::CS_W;
    localparam int QF   = rvr_pkg::QF;
    localparam int PW   = K_W + W;        // k*v
    localparam int DTW  = PW + 2;         // dot / cross sums
    localparam int VCW  = W + CS_W;       // v*cos
    localparam int EW   = W + 2;          // d, cross, k*d rounded
    localparam int TW   = W + 3;          // rounded result terms
    localparam int KDW  = K_W + EW;
    localparam int CRW  = EW + CS_W;
    localparam int OW   = CS_W + 1;       // 1 - cos
    localparam int KOW  = EW + OW;
    localparam int SW   = W + 5;

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [W-1:0]    v [3];
    logic signed [K_W-1:0]  k [3];

    // stage 1
    logic signed [PW-1:0]   kv_reg [3][3];
    logic signed [VCW-1:0]  vc_reg [3];
    logic signed [K_W-1:0]  k1_reg [3];
    logic signed [CS_W-1:0] c1_reg;
    logic signed [CS_W-1:0] s1_reg;
    // stage 2
    logic signed [DTW-1:0]  dot_sum;
    logic signed [DTW-1:0]  cr_sum [3];
    logic signed [VCW-1:0]  vc_rnd [3];
    logic signed [EW-1:0]   d_reg;
    logic signed [EW-1:0]   cr_reg [3];
    logic signed [TW-1:0]   vc2_reg [3];
    logic signed [K_W-1:0]  k2_reg [3];
    logic signed [CS_W-1:0] c2_reg;
    logic signed [CS_W-1:0] s2_reg;
    // stage 3
    logic signed [KDW-1:0]  kd_reg [3];
    logic signed [CRW-1:0]  crs_reg [3];
    logic signed [TW-1:0]   vc3_reg [3];
    logic signed [OW-1:0]   omc3_reg;
    // stage 4
    logic signed [KDW-1:0]  kd_rnd [3];
    logic signed [CRW-1:0]  crs_rnd [3];
    logic signed [EW-1:0]   kdr_reg [3];
    logic signed [TW-1:0]   csr4_reg [3];
    logic signed [TW-1:0]   vc4_reg [3];
    logic signed [OW-1:0]   omc4_reg;
    // stage 5
    logic signed [KOW-1:0]  ko_reg [3];
    logic signed [TW-1:0]   csr5_reg [3];
    logic signed [TW-1:0]   vc5_reg [3];
    // stage 6
    logic signed [KOW-1:0]  ko_rnd [3];
    logic signed [SW-1:0]   tot [3];
    logic signed [W-1:0]    rot_next [3];
    logic signed [W-1:0]    rot_reg [3];

    assign v[0] = vec_x;
    assign v[1] = vec_y;
    assign v[2] = vec_z;
    assign k[0] = k_x;
    assign k[1] = k_y;
    assign k[2] = k_z;

    // round half up of the Q.30 factor: (x + 2^29) >>> 30
    always_comb
    begin
        dot_sum = (DTW'(kv_reg[0][0]) + DTW'(kv_reg[1][1]) + DTW'(kv_reg[2][2]))
                + DTW'(rvr_pkg::RND_HALF);
        cr_sum[0] = DTW'(kv_reg[1][2]) - DTW'(kv_reg[2][1]) + DTW'(rvr_pkg::RND_HALF);
        cr_sum[1] = DTW'(kv_reg[2][0]) - DTW'(kv_reg[0][2]) + DTW'(rvr_pkg::RND_HALF);
        cr_sum[2] = DTW'(kv_reg[0][1]) - DTW'(kv_reg[1][0]) + DTW'(rvr_pkg::RND_HALF);
        for (int i = 0; i < 3; i++)
        begin
            vc_rnd[i]  = vc_reg[i] + VCW'(rvr_pkg::RND_HALF);
            kd_rnd[i]  = kd_reg[i] + KDW'(rvr_pkg::RND_HALF);
            crs_rnd[i] = crs_reg[i] + CRW'(rvr_pkg::RND_HALF);
            ko_rnd[i]  = ko_reg[i] + KOW'(rvr_pkg::RND_HALF);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tot[i] = SW'(vc5_reg[i]) + SW'(csr5_reg[i]) + SW'(TW'(ko_rnd[i] >>> QF));
            if (tot[i] > SAT_HI)
            begin
                rot_next[i] = W'(SAT_HI);
            end
            else if (tot[i] < SAT_LO)
            begin
                rot_next[i] = W'(SAT_LO);
            end
            else
            begin
                rot_next[i] = W'(tot[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    kv_reg[i][j] <= PW'(k[i]) * PW'(v[j]);
                end
                vc_reg[i] <= VCW'(v[i]) * VCW'(cos_v);
                k1_reg[i] <= k[i];

                cr_reg[i]  <= EW'(cr_sum[i] >>> QF);
                vc2_reg[i] <= TW'(vc_rnd[i] >>> QF);
                k2_reg[i]  <= k1_reg[i];

                kd_reg[i]  <= KDW'(k2_reg[i]) * KDW'(d_reg);
                crs_reg[i] <= CRW'(cr_reg[i]) * CRW'(s2_reg);
                vc3_reg[i] <= vc2_reg[i];

                kdr_reg[i]  <= EW'(kd_rnd[i] >>> QF);
                csr4_reg[i] <= TW'(crs_rnd[i] >>> QF);
                vc4_reg[i]  <= vc3_reg[i];

                ko_reg[i]   <= KOW'(kdr_reg[i]) * KOW'(omc4_reg);
                csr5_reg[i] <= csr4_reg[i];
                vc5_reg[i]  <= vc4_reg[i];

                rot_reg[i] <= rot_next[i];
            end
            c1_reg   <= cos_v;
            s1_reg   <= sin_v;
            d_reg    <= EW'(dot_sum >>> QF);
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            omc3_reg <= OW'(rvr_pkg::Q30_ONE) - OW'(c2_reg);
            omc4_reg <= omc3_reg;
        end
    end

    assign rot_x = rot_reg[0];
    assign rot_y = rot_reg[1];
    assign rot_z = rot_reg[2];

endmodule
